/* sv/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising clock edge outside reset
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define SLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/slt_pkg.sv */
// types, codes and control store of the sorted linked list table
package slt_pkg;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned LINK_W   = SLOT_W + 1;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned PC_W     = 4;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

  localparam logic [1:0] KIND_INS  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_SRCH = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // control store addresses
  localparam logic [PC_W-1:0] U_IDLE = 4'd0;
  localparam logic [PC_W-1:0] U_CHK  = 4'd1;
  localparam logic [PC_W-1:0] U_CHK2 = 4'd2;
  localparam logic [PC_W-1:0] U_WALK = 4'd3;
  localparam logic [PC_W-1:0] U_DISP = 4'd4;
  localparam logic [PC_W-1:0] U_SRCH = 4'd5;
  localparam logic [PC_W-1:0] U_INS0 = 4'd6;
  localparam logic [PC_W-1:0] U_INS1 = 4'd7;
  localparam logic [PC_W-1:0] U_INS2 = 4'd8;
  localparam logic [PC_W-1:0] U_DEL0 = 4'd9;
  localparam logic [PC_W-1:0] U_DEL1 = 4'd10;
  localparam logic [PC_W-1:0] U_DEL2 = 4'd11;
  localparam logic [PC_W-1:0] U_DUP  = 4'd12;
  localparam logic [PC_W-1:0] U_FULL = 4'd13;
  localparam logic [PC_W-1:0] U_NF   = 4'd14;
  localparam logic [PC_W-1:0] U_OUT  = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_CUR,
    OP_WALK,
    OP_SRCH,
    OP_RD_FREE,
    OP_INS_LINK,
    OP_INS_HOOK,
    OP_DEL_UNLINK,
    OP_DEL_FREE,
    OP_SET_DUP,
    OP_SET_FULL,
    OP_SET_NF,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_ACCEPT,
    C_FULL,
    C_BADKIND,
    C_LESS,
    C_KIND,
    C_MATCH,
    C_NOMATCH,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      U_IDLE:  w = '{op: OP_LOAD,       cond: C_ACCEPT,   target: U_CHK};
      U_CHK:   w = '{op: OP_NOP,        cond: C_FULL,     target: U_FULL};
      U_CHK2:  w = '{op: OP_RD_CUR,     cond: C_BADKIND,  target: U_NF};
      U_WALK:  w = '{op: OP_WALK,       cond: C_LESS,     target: U_WALK};
      U_DISP:  w = '{op: OP_NOP,        cond: C_KIND,     target: U_SRCH};
      U_SRCH:  w = '{op: OP_SRCH,       cond: C_ALWAYS,   target: U_OUT};
      U_INS0:  w = '{op: OP_RD_FREE,    cond: C_MATCH,    target: U_DUP};
      U_INS1:  w = '{op: OP_INS_LINK,   cond: C_NEXT,     target: U_INS2};
      U_INS2:  w = '{op: OP_INS_HOOK,   cond: C_ALWAYS,   target: U_OUT};
      U_DEL0:  w = '{op: OP_NOP,        cond: C_NOMATCH,  target: U_NF};
      U_DEL1:  w = '{op: OP_DEL_UNLINK, cond: C_NEXT,     target: U_DEL2};
      U_DEL2:  w = '{op: OP_DEL_FREE,   cond: C_ALWAYS,   target: U_OUT};
      U_DUP:   w = '{op: OP_SET_DUP,    cond: C_ALWAYS,   target: U_OUT};
      U_FULL:  w = '{op: OP_SET_FULL,   cond: C_ALWAYS,   target: U_OUT};
      U_NF:    w = '{op: OP_SET_NF,     cond: C_ALWAYS,   target: U_OUT};
      U_OUT:   w = '{op: OP_EMIT,       cond: C_OUT_FREE, target: U_IDLE};
      default: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/slt_req_if.sv */
// request channel: operation kind and key
interface slt_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic signed [31:0]  key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

/* sv/slt_rsp_if.sv */
// response channel: status, slot and element count
interface slt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] slot;
  logic [6:0] count;

  modport source (output valid, output status, output slot, output count, input ready);
  modport sink   (input valid, input status, input slot, input count, output ready);
endinterface

/* sv/sorted_linked_list_table.sv */
// Sorted set of signed keys kept as a linked list in a 64-slot array, with a free
// list of unused slots. One request (insert, delete, search) is taken at a time
// and yields one response item with status, slot and the element count. After
// acceptance a request passes a check step, a read step, a walk step for each
// list entry passed and one more, and the search, insert or delete steps before
// its emit step (an insert into a full table or an unused kind skips the walk);
// the sequencer then returns to its idle step. The walk reads one key and
// one link per cycle from the slot memories, and a small microprogram steps the
// datapath. The next request is taken while the previous response still waits in
// its output register, and stalls in its last step until that register is free;
// no clearing pass is needed after reset.
`include "assert_macros.svh"

module sorted_linked_list_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  slt_req_if.sink        req_i,
  slt_rsp_if.source      rsp_o
);

  localparam int unsigned SW = slt_pkg::SLOT_W;
  localparam int unsigned LW = slt_pkg::LINK_W;
  localparam int unsigned KW = slt_pkg::KEY_BITS;

  // sequencer
  logic [slt_pkg::PC_W-1:0] pc_q, pc_d;
  slt_pkg::uword_t          uw;

  // datapath registers
  logic [1:0]          kind_q, kind_d;
  logic signed [KW-1:0] key_q, key_d;
  logic [LW-1:0]       prev_q, prev_d;
  logic [LW-1:0]       cur_q, cur_d;
  logic [LW-1:0]       steps_q, steps_d;
  logic                match_q, match_d;
  logic [LW-1:0]       head_q, head_d;
  logic [LW-1:0]       free_q, free_d;
  logic [LW-1:0]       count_q, count_d;
  logic [1:0]          st_q, st_d;
  logic [SW-1:0]       slot_q, slot_d;

  // output register
  logic                ovld_q, ovld_d;
  logic [1:0]          ost_q, ost_d;
  logic [SW-1:0]       oslot_q, oslot_d;
  logic [LW-1:0]       ocnt_q, ocnt_d;

  // slot memories
  logic signed [KW-1:0] key_mem [slt_pkg::SLOTS];
  logic [LW-1:0]       link_mem [slt_pkg::SLOTS];
  logic [slt_pkg::SLOTS-1:0] lvld_q, lvld_d;
  logic                rd_en;
  logic [SW-1:0]       rd_addr;
  logic [SW-1:0]       rd_addr_q;
  logic signed [KW-1:0] key_rd_q;
  logic [LW-1:0]       link_rd_q;
  logic                lvld_rd_q;
  logic [LW-1:0]       link_eff;
  logic                key_we;
  logic                link_we;
  logic [SW-1:0]       link_wa;
  logic [LW-1:0]       link_wd;

  logic req_fire;
  logic out_free;
  logic less;
  logic bad_kind;

  assign uw       = slt_pkg::ucode(pc_q);
  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !ovld_q || rsp_o.ready;
  // an unwritten link reads as its reset value, the next slot
  assign link_eff = lvld_rd_q ? link_rd_q : ({1'b0, rd_addr_q} + LW'(1));
  assign less     = (cur_q != slt_pkg::NULL_LINK) && (steps_q < LW'(slt_pkg::SLOTS))
                    && (key_rd_q < key_q);
  assign bad_kind = (kind_q != slt_pkg::KIND_INS) && (kind_q != slt_pkg::KIND_DEL)
                    && (kind_q != slt_pkg::KIND_SRCH);

  assign req_i.ready  = (pc_q == slt_pkg::U_IDLE);
  assign rsp_o.valid  = ovld_q;
  assign rsp_o.status = ost_q;
  assign rsp_o.slot   = oslot_q;
  assign rsp_o.count  = ocnt_q;

  // next step
  always_comb begin
    pc_d = pc_q + slt_pkg::PC_W'(1);
    unique case (uw.cond)
      slt_pkg::C_NEXT:     pc_d = pc_q + slt_pkg::PC_W'(1);
      slt_pkg::C_ALWAYS:   pc_d = uw.target;
      slt_pkg::C_ACCEPT:   pc_d = req_fire ? uw.target : pc_q;
      slt_pkg::C_FULL: begin
        if (kind_q == slt_pkg::KIND_INS && free_q == slt_pkg::NULL_LINK) pc_d = uw.target;
      end
      slt_pkg::C_BADKIND: begin
        if (bad_kind) pc_d = uw.target;
      end
      slt_pkg::C_LESS: begin
        if (less) pc_d = uw.target;
      end
      slt_pkg::C_KIND: begin
        if (kind_q == slt_pkg::KIND_INS) pc_d = slt_pkg::U_INS0;
        else if (kind_q == slt_pkg::KIND_DEL) pc_d = slt_pkg::U_DEL0;
        else pc_d = uw.target;
      end
      slt_pkg::C_MATCH: begin
        if (match_q) pc_d = uw.target;
      end
      slt_pkg::C_NOMATCH: begin
        if (!match_q) pc_d = uw.target;
      end
      slt_pkg::C_OUT_FREE: pc_d = out_free ? uw.target : pc_q;
      default:             pc_d = slt_pkg::U_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    kind_d  = kind_q;
    key_d   = key_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    steps_d = steps_q;
    match_d = match_q;
    head_d  = head_q;
    free_d  = free_q;
    count_d = count_q;
    st_d    = st_q;
    slot_d  = slot_q;
    ovld_d  = ovld_q && !rsp_o.ready;
    ost_d   = ost_q;
    oslot_d = oslot_q;
    ocnt_d  = ocnt_q;
    lvld_d  = lvld_q;
    rd_en   = 1'b0;
    rd_addr = cur_q[SW-1:0];
    key_we  = 1'b0;
    link_we = 1'b0;
    link_wa = cur_q[SW-1:0];
    link_wd = free_q;
    unique case (uw.op)
      slt_pkg::OP_NOP: begin
      end
      slt_pkg::OP_LOAD: begin
        if (req_fire) begin
          kind_d  = req_i.kind;
          key_d   = KW'(req_i.key);
          prev_d  = slt_pkg::NULL_LINK;
          cur_d   = head_q;
          steps_d = '0;
        end
      end
      slt_pkg::OP_RD_CUR: begin
        rd_en = 1'b1;
      end
      slt_pkg::OP_WALK: begin
        if (less) begin
          prev_d  = cur_q;
          cur_d   = link_eff;
          steps_d = steps_q + LW'(1);
          rd_en   = 1'b1;
          rd_addr = link_eff[SW-1:0];
        end else begin
          match_d = (cur_q != slt_pkg::NULL_LINK) && (key_rd_q == key_q);
        end
      end
      slt_pkg::OP_SRCH: begin
        st_d   = match_q ? slt_pkg::ST_DONE : slt_pkg::ST_NF;
        slot_d = match_q ? cur_q[SW-1:0] : '0;
      end
      slt_pkg::OP_RD_FREE: begin
        rd_en   = 1'b1;
        rd_addr = free_q[SW-1:0];
      end
      slt_pkg::OP_INS_LINK: begin
        free_d  = link_eff;
        slot_d  = free_q[SW-1:0];
        key_we  = 1'b1;
        link_we = 1'b1;
        link_wa = free_q[SW-1:0];
        link_wd = cur_q;
      end
      slt_pkg::OP_INS_HOOK: begin
        if (prev_q == slt_pkg::NULL_LINK) begin
          head_d = {1'b0, slot_q};
        end else begin
          link_we = 1'b1;
          link_wa = prev_q[SW-1:0];
          link_wd = {1'b0, slot_q};
        end
        count_d = count_q + LW'(1);
        st_d    = slt_pkg::ST_DONE;
      end
      slt_pkg::OP_DEL_UNLINK: begin
        if (prev_q == slt_pkg::NULL_LINK) begin
          head_d = link_eff;
        end else begin
          link_we = 1'b1;
          link_wa = prev_q[SW-1:0];
          link_wd = link_eff;
        end
      end
      slt_pkg::OP_DEL_FREE: begin
        link_we = 1'b1;
        link_wa = cur_q[SW-1:0];
        link_wd = free_q;
        free_d  = cur_q;
        if (count_q != '0) count_d = count_q - LW'(1);
        st_d    = slt_pkg::ST_DONE;
        slot_d  = cur_q[SW-1:0];
      end
      slt_pkg::OP_SET_DUP: begin
        st_d   = slt_pkg::ST_DUP;
        slot_d = '0;
      end
      slt_pkg::OP_SET_FULL: begin
        st_d   = slt_pkg::ST_FULL;
        slot_d = '0;
      end
      slt_pkg::OP_SET_NF: begin
        st_d   = slt_pkg::ST_NF;
        slot_d = '0;
      end
      slt_pkg::OP_EMIT: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ost_d   = st_q;
          oslot_d = slot_q;
          ocnt_d  = count_q;
        end
      end
      default: begin
      end
    endcase
    if (link_we) lvld_d[link_wa] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= slt_pkg::U_IDLE;
      head_q  <= slt_pkg::NULL_LINK;
      free_q  <= '0;
      count_q <= '0;
      ovld_q  <= 1'b0;
      lvld_q  <= '0;
      match_q <= 1'b0;
      steps_q <= '0;
    end else begin
      pc_q    <= pc_d;
      head_q  <= head_d;
      free_q  <= free_d;
      count_q <= count_d;
      ovld_q  <= ovld_d;
      lvld_q  <= lvld_d;
      match_q <= match_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    key_q   <= key_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    st_q    <= st_d;
    slot_q  <= slot_d;
    ost_q   <= ost_d;
    oslot_q <= oslot_d;
    ocnt_q  <= ocnt_d;
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[free_q[SW-1:0]] <= key_q;
    if (rd_en) key_rd_q <= key_mem[rd_addr];
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (rd_en) begin
      link_rd_q <= link_mem[rd_addr];
      lvld_rd_q <= lvld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  `SLT_ASSERT(a_count_range, count_q <= LW'(slt_pkg::SLOTS), "element count above slot count")
  `SLT_ASSERT_IMP(a_free_vs_count, pc_q != slt_pkg::U_INS2,
    (free_q == slt_pkg::NULL_LINK) == (count_q == LW'(slt_pkg::SLOTS)),
    "free list and element count disagree")
  `SLT_ASSERT_IMP(a_slot_zero, ovld_q && ost_q != slt_pkg::ST_DONE, oslot_q == '0,
    "refused item reports a nonzero slot")
  `SLT_ASSERT_IMP(a_emit_step, $rose(ovld_q), $past(pc_q) == slt_pkg::U_OUT,
    "response raised outside the emit step")

endmodule
